@@ sv/phpn_pkg.sv @@
// Shared types, constants and helper functions of the pseudo-Hessian normalizer.
// No dependencies; imported by the divider, square root and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package phpn_pkg;

	localparam int unsigned DIV_W = 64;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [63:0] RND_Q16 = 64'h0000_0000_0000_8000;
	localparam logic [23:0] EPS_RESET = 24'd1678;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_THR,
		ST_P_RD,
		ST_P_PREP,
		ST_P_DIV,
		ST_P_WAIT,
		ST_P_SQ,
		ST_P_ACC,
		ST_R_DIV,
		ST_R_WAIT,
		ST_R_SWAIT,
		ST_F_RD,
		ST_F_PREP,
		ST_F_DIV,
		ST_F_WAIT,
		ST_F_MUL,
		ST_F_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic long_mode;
	} div_ctl_t;

	// Clamp a magnitude with sign to a signed 32-bit two's complement word.
	function automatic logic [31:0] sat_s32(input logic [63:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
		end else begin
			r = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return r;
	endfunction

	// Clamp a magnitude to the largest magnitude that sat_s32 can return.
	function automatic logic [31:0] sat_mag32(input logic [63:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : mag[31:0];
		end else begin
			r = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/phpn_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module phpn_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/phpn_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, 32 or 64 iterations.
// Depends on phpn_pkg for the datapath width and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module phpn_div
	import phpn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         ctl,
	input  wire logic [DIV_W-1:0] num_hi,
	input  wire logic [DIV_W-1:0] num_lo,
	input  wire logic [DIV_W-1:0] den,
	output logic                  done,
	output logic      [DIV_W-1:0] quo
);

	logic             run_q;
	logic             done_q;
	logic             ovf_q;
	logic [6:0]       cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] lo_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   trial;
	logic             take;

	assign trial = {rem_q, lo_q[DIV_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				// quotient would not fit: saturate at once
				if (num_hi >= den) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q <= 1'b0;
					run_q <= 1'b1;
					cnt_q <= ctl.long_mode ? 7'd64 : 7'd32;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
			lo_q  <= {lo_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = ovf_q ? {DIV_W{1'b1}} : quo_q;

endmodule

`default_nettype wire

@@ sv/phpn_sqrt.sv @@
// Bit-serial integer square root of a 64-bit radicand, two radicand bits per cycle.
// Depends on phpn_pkg for the datapath width.
`timescale 1ns / 1ps
`default_nettype none

module phpn_sqrt
	import phpn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] rad,
	output logic                  done,
	output logic      [31:0]      root
);

	logic             run_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [DIV_W-1:0] rad_q;
	logic [33:0]      rem_q;
	logic [31:0]      root_q;
	logic [35:0]      t;
	logic [35:0]      trial;
	logic             take;

	assign t     = {rem_q, rad_q[DIV_W-1:DIV_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign take  = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[DIV_W-3:0], 2'b00};
			rem_q  <= take ? 34'(t - trial) : t[33:0];
			root_q <= {root_q[30:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

@@ sv/pseudo_hessian_precondition_normalize_core.sv @@
// Top level of the diagonal pseudo-Hessian preconditioner with norm-preserving scale.
// Depends on phpn_pkg, phpn_ram, phpn_div and phpn_sqrt.
`timescale 1ns / 1ps
`default_nettype none

// Load transfers (func 0) write one gradient/Hessian pair into a single 64-bit wide
// RAM while it has room and track the Hessian maximum. The load marked last_in
// starts the pass: state ST_THR forms the threshold eps_ratio * maximum, then
// each stored element goes through RAM read, operand setup, a 32-step restoring
// divide, squaring and accumulation, and the pass closes with a 64-step ratio
// divide and a 32-step square root. The divider is shared. Fetch transfers
// (func 1) return one scaled element each, again through the divider, or pass the
// gradient through when the Hessian maximum was zero. A fetch that finds no ready
// element gives no result. req_stall is high while an item is at work; a finished
// result waits in the output register, and the next request is taken meanwhile.
// Loads and reads of the RAM never overlap, so no forwarding is needed. The RAM is
// not cleared; only entries written for the current vector are read.
module pseudo_hessian_precondition_normalize_core
	import phpn_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic        [23:0] cfg_wr_data,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               func,
	input  wire logic signed [31:0] grad_value,
	input  wire logic        [31:0] hess_value,
	input  wire logic               last_in,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic signed      [31:0] precond_value,
	output logic             [9:0]  element_index,
	output logic             [31:0] scale_factor,
	output logic                    copied_unchanged,
	output logic                    last_out
);

	localparam int unsigned AW = $clog2(MAX_ELEMENTS);
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	state_t state_q, state_d;

	// Architectural state
	logic [23:0]    eps_q;
	logic [CW-1:0]  cnt_q;
	logic [31:0]    hmax_q;
	logic [CW-1:0]  rptr_q;
	logic [CW-1:0]  pidx_q;
	logic [63:0]    gsum_q;
	logic [63:0]    psum_q;
	logic [31:0]    scale_q;
	logic [31:0]    thr_q;
	logic           ready_q;
	logic           copy_q;

	// Element datapath
	logic [55:0]    num_q;
	logic [32:0]    den_q;
	logic [31:0]    gm_q;
	logic           gneg_q;
	logic [31:0]    graw_q;
	logic [31:0]    pmag_q;
	logic [63:0]    gsq_q;
	logic [63:0]    psq_q;
	logic [63:0]    prod_q;

	// Output register
	logic           rsp_valid_q;
	logic [31:0]    val_q;
	logic [9:0]     idx_q;
	logic [31:0]    scl_q;
	logic           copied_q;
	logic           last_q;

	logic           accept;
	logic           out_free;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [AW-1:0]  ram_raddr;
	logic [63:0]    ram_rdata;
	logic [CW-1:0]  eff_cnt;
	logic [31:0]    eff_max;
	logic           store;
	logic [31:0]    new_max;
	logic [31:0]    g_rd;
	logic [31:0]    h_rd;
	logic           gneg_rd;
	logic [31:0]    gm_rd;
	logic [32:0]    den_rd;
	logic [55:0]    num_rd;
	logic [55:0]    thr_prod;
	logic [63:0]    rnd;
	div_ctl_t       div_ctl;
	logic [63:0]    div_hi;
	logic [63:0]    div_lo;
	logic [63:0]    div_den;
	logic           div_done;
	logic [63:0]    div_quo;
	logic           sq_start;
	logic           sq_done;
	logic [31:0]    sq_root;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// A load after a finished pass drops the ready vector and opens a new one.
	assign eff_cnt   = ready_q ? '0 : cnt_q;
	assign eff_max   = ready_q ? '0 : hmax_q;
	assign store     = eff_cnt < MAX_CNT;
	assign new_max   = (store && (hess_value > eff_max)) ? hess_value : eff_max;
	assign ram_we    = accept && (func == FUNC_LOAD) && store;
	assign ram_waddr = eff_cnt[AW-1:0];

	phpn_ram #(
		.WIDTH(64),
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({grad_value, hess_value}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		case (state_q)
			ST_F_RD, ST_F_PREP: ram_raddr = rptr_q[AW-1:0];
			default:            ram_raddr = pidx_q[AW-1:0];
		endcase
	end

	// Operand setup: gp = (|g| * 2^24 + den/2) / den, den = h + threshold
	assign g_rd    = ram_rdata[63:32];
	assign h_rd    = ram_rdata[31:0];
	assign gneg_rd = g_rd[31];
	assign gm_rd   = gneg_rd ? (~g_rd + 32'd1) : g_rd;
	assign den_rd  = {1'b0, h_rd} + {1'b0, thr_q};
	assign num_rd  = {gm_rd, 24'd0} + 56'(den_rd[32:1]);

	assign thr_prod = {32'd0, eps_q} * {24'd0, hmax_q};

	// Divider is shared by the element quotients and the closing norm ratio.
	always_comb begin
		if (state_q == ST_R_DIV) begin
			div_hi  = {32'd0, gsum_q[63:32]};
			div_lo  = {gsum_q[31:0], 32'd0};
			div_den = psum_q;
		end else begin
			div_hi  = {40'd0, num_q[55:32]};
			div_lo  = {num_q[31:0], 32'd0};
			div_den = {31'd0, den_q};
		end
	end

	phpn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.num_hi(div_hi),
		.num_lo(div_lo),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	phpn_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.rad   (div_quo),
		.done  (sq_done),
		.root  (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and unit strobes
	always_comb begin
		state_d           = state_q;
		div_ctl.start     = 1'b0;
		div_ctl.long_mode = 1'b0;
		sq_start          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_LOAD) begin
						if (last_in && (new_max != 32'd0)) begin
							state_d = ST_THR;
						end
					end else if (ready_q && (rptr_q < cnt_q)) begin
						state_d = ST_F_RD;
					end
				end
			end
			ST_THR:    state_d = (cnt_q == '0) ? ST_R_DIV : ST_P_RD;
			ST_P_RD:   state_d = ST_P_PREP;
			ST_P_PREP: state_d = ST_P_DIV;
			ST_P_DIV: begin
				div_ctl.start = 1'b1;
				state_d       = ST_P_WAIT;
			end
			ST_P_WAIT: begin
				if (div_done) begin
					state_d = ST_P_SQ;
				end
			end
			ST_P_SQ:   state_d = ST_P_ACC;
			ST_P_ACC:  state_d = ((pidx_q + CW'(1)) == cnt_q) ? ST_R_DIV : ST_P_RD;
			ST_R_DIV: begin
				if (psum_q == 64'd0) begin
					state_d = ST_IDLE;
				end else begin
					div_ctl.start     = 1'b1;
					div_ctl.long_mode = 1'b1;
					state_d           = ST_R_WAIT;
				end
			end
			ST_R_WAIT: begin
				if (div_done) begin
					sq_start = 1'b1;
					state_d  = ST_R_SWAIT;
				end
			end
			ST_R_SWAIT: begin
				if (sq_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_F_RD:   state_d = ST_F_PREP;
			ST_F_PREP: state_d = copy_q ? ST_F_OUT : ST_F_DIV;
			ST_F_DIV: begin
				div_ctl.start = 1'b1;
				state_d       = ST_F_WAIT;
			end
			ST_F_WAIT: begin
				if (div_done) begin
					state_d = ST_F_MUL;
				end
			end
			ST_F_MUL:  state_d = ST_F_OUT;
			ST_F_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= EPS_RESET;
			cnt_q   <= '0;
			hmax_q  <= '0;
			rptr_q  <= '0;
			pidx_q  <= '0;
			gsum_q  <= '0;
			psum_q  <= '0;
			scale_q <= ONE_Q16;
			thr_q   <= '0;
			ready_q <= 1'b0;
			copy_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				eps_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == FUNC_LOAD)) begin
						cnt_q   <= eff_cnt + CW'(store);
						hmax_q  <= new_max;
						ready_q <= 1'b0;
						if (ready_q || last_in) begin
							rptr_q <= '0;
						end
						if (last_in) begin
							gsum_q <= '0;
							psum_q <= '0;
							// all-zero Hessian: pass the gradient through
							if (new_max == 32'd0) begin
								ready_q <= 1'b1;
								copy_q  <= 1'b1;
								scale_q <= ONE_Q16;
							end else begin
								copy_q <= 1'b0;
							end
						end
					end
				end
				ST_THR: begin
					thr_q  <= (thr_prod[55:24] == 32'd0) ? 32'd1 : thr_prod[55:24];
					pidx_q <= '0;
				end
				ST_P_ACC: begin
					gsum_q <= sat_add64(gsum_q, gsq_q);
					psum_q <= sat_add64(psum_q, psq_q);
					pidx_q <= pidx_q + CW'(1);
				end
				ST_R_DIV: begin
					if (psum_q == 64'd0) begin
						scale_q <= ONE_Q16;
						ready_q <= 1'b1;
					end
				end
				ST_R_SWAIT: begin
					if (sq_done) begin
						scale_q <= sq_root;
						ready_q <= 1'b1;
					end
				end
				ST_F_OUT: begin
					if (out_free) begin
						rptr_q <= rptr_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Element datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_P_PREP) || (state_q == ST_F_PREP)) begin
			num_q  <= num_rd;
			den_q  <= den_rd;
			gm_q   <= gm_rd;
			gneg_q <= gneg_rd;
			graw_q <= g_rd;
		end
		if (((state_q == ST_P_WAIT) || (state_q == ST_F_WAIT)) && div_done) begin
			pmag_q <= sat_mag32(div_quo, gneg_q);
		end
		if (state_q == ST_P_SQ) begin
			gsq_q <= {32'd0, gm_q} * {32'd0, gm_q};
			psq_q <= {32'd0, pmag_q} * {32'd0, pmag_q};
		end
		if (state_q == ST_F_MUL) begin
			prod_q <= {32'd0, pmag_q} * {32'd0, scale_q};
		end
	end

	// Round the Q16.16 scaling to nearest, ties away from zero.
	assign rnd = prod_q + RND_Q16;

	// Output register: hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_F_OUT) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Capture the scale with the result so a later pass cannot alter a held transfer.
	always_ff @(posedge clk) begin
		if ((state_q == ST_F_OUT) && out_free) begin
			val_q    <= copy_q ? graw_q : sat_s32({16'd0, rnd[63:16]}, gneg_q);
			idx_q    <= 10'(rptr_q[AW-1:0]);
			scl_q    <= scale_q;
			copied_q <= copy_q;
			last_q   <= (rptr_q + CW'(1)) == cnt_q;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign precond_value    = $signed(val_q);
	assign element_index    = idx_q;
	assign scale_factor     = scl_q;
	assign copied_unchanged = copied_q;
	assign last_out         = last_q;

endmodule

`default_nettype wire

@@ verif/phpn_scoreboard.sv @@
// Checker for pseudo_hessian_precondition_normalize_core: watches both channels and the
// config port, predicts every fetch result and compares. Depends on phpn_pkg.
`timescale 1ns / 1ps

module phpn_scoreboard
	import phpn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        func,
	input  logic [31:0] grad_value,
	input  logic [31:0] hess_value,
	input  logic        last_in,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [31:0] precond_value,
	input  logic [9:0]  element_index,
	input  logic [31:0] scale_factor,
	input  logic        copied_unchanged,
	input  logic        last_out,
	output int          errors,
	output int          pending
);
	localparam int DEPTH = 1024;

	typedef struct packed {
		logic [31:0] value;
		logic [9:0]  index;
		logic [31:0] scale;
		logic        copied;
		logic        last;
	} fetch_result_t;

	fetch_result_t due_q[$];

	logic [31:0] grad_mem [DEPTH];
	logic [31:0] hess_mem [DEPTH];
	logic [31:0] hmax;
	int unsigned n_elem, rd_ptr;
	logic [31:0] scale_q16;
	logic [23:0] eps;
	logic [63:0] thr;
	logic        ready, copy_mode;
	int          err_cnt;

	function automatic logic [63:0] mag_of(input logic [31:0] v);
		return v[31] ? 64'(-$signed({{32{v[31]}}, v})) : {32'd0, v};
	endfunction

	function automatic logic [63:0] clamp_mag(input logic [63:0] m, input logic neg);
		if (neg)
			return (m > 64'h8000_0000) ? 64'h8000_0000 : m;
		return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
	endfunction

	function automatic logic [31:0] to_word(input logic [63:0] m, input logic neg);
		return neg ? -m[31:0] : m[31:0];
	endfunction

	// divide one gradient element by its regularized Hessian value; returns magnitude
	function automatic logic [63:0] scaled_mag(input int unsigned i);
		logic [63:0] den;
		den = {32'd0, hess_mem[i]} + thr;
		return clamp_mag(((mag_of(grad_mem[i]) << 24) + den / 2) / den, grad_mem[i][31]);
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] norm_ratio(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q, r;
		logic carry;
		if ((num >> 32) >= den)
			return '1;
		q = num / den;
		r = num % den;
		for (int k = 0; k < 32; k++) begin
			carry = r[63];
			r = r << 1;
			q = q << 1;
			if (carry || r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void norm_pass();
		logic [63:0] gsum, psum, t, gm, pm;
		gsum = 0;
		psum = 0;
		rd_ptr = 0;
		ready = 1'b1;
		if (hmax == 0) begin
			copy_mode = 1'b1;
			scale_q16 = ONE_Q16;
			return;
		end
		copy_mode = 1'b0;
		t = ({40'd0, eps} * {32'd0, hmax}) >> 24;
		thr = (t == 0) ? 64'd1 : t;
		for (int unsigned i = 0; i < n_elem; i++) begin
			gm = mag_of(grad_mem[i]);
			pm = scaled_mag(i);
			gsum = add_sat(gsum, gm * gm);
			psum = add_sat(psum, pm * pm);
		end
		if (psum == 0) begin
			scale_q16 = ONE_Q16;
		end else begin
			t = root64(norm_ratio(gsum, psum));
			scale_q16 = t[31:0];
		end
	endfunction

	always @(posedge clk) begin
		fetch_result_t e, got;
		logic [63:0] pm;
		if (!arst_n) begin
			due_q.delete();
			hmax = 0;
			n_elem = 0;
			rd_ptr = 0;
			scale_q16 = ONE_Q16;
			eps = EPS_RESET;
			thr = 0;
			ready = 1'b0;
			copy_mode = 1'b0;
			err_cnt = 0;
		end else begin
			if (cfg_wr_en)
				eps = cfg_wr_data;
			if (rsp_valid && !rsp_stall) begin
				got = '{precond_value, element_index, scale_factor, copied_unchanged, last_out};
				if (due_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("ERROR unexpected result value=%h index=%0d", got.value, got.index);
				end else begin
					e = due_q.pop_front();
					if (got !== e) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"ERROR result mismatch: expected value=%h index=%0d ",
								"scale=%h copied=%b last=%b, got value=%h index=%0d ",
								"scale=%h copied=%b last=%b"}, e.value, e.index, e.scale,
								e.copied, e.last, got.value, got.index, got.scale,
								got.copied, got.last);
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (func == FUNC_LOAD) begin
					// a load after a finished pass drops that vector
					if (ready) begin
						ready = 1'b0;
						n_elem = 0;
						hmax = 0;
						rd_ptr = 0;
					end
					if (n_elem < DEPTH) begin
						grad_mem[n_elem] = grad_value;
						hess_mem[n_elem] = hess_value;
						if (hess_value > hmax)
							hmax = hess_value;
						n_elem++;
					end
					if (last_in)
						norm_pass();
				end else if (ready && rd_ptr < n_elem) begin
					e.index = rd_ptr[9:0];
					e.scale = scale_q16;
					e.copied = copy_mode;
					e.last = (rd_ptr + 1 == n_elem);
					if (copy_mode) begin
						e.value = grad_mem[rd_ptr];
					end else begin
						pm = scaled_mag(rd_ptr) * {32'd0, scale_q16};
						e.value = to_word(clamp_mag((pm + RND_Q16) >> 16,
							grad_mem[rd_ptr][31]), grad_mem[rd_ptr][31]);
					end
					due_q.push_back(e);
					rd_ptr++;
				end
			end
		end
		errors <= err_cnt;
		pending <= due_q.size();
	end

endmodule

@@ verif/tb_pseudo_hessian_precondition_normalize_core.sv @@
// Testbench top for pseudo_hessian_precondition_normalize_core: clock, reset, stimulus,
// idling and verdict. Depends on phpn_pkg and the phpn_scoreboard checker.
`timescale 1ns / 1ps

module tb_pseudo_hessian_precondition_normalize_core;
	import phpn_pkg::*;

	localparam int STALL_LIMIT = 200000; // a full 1024-element pass is well under this
	localparam int RANDOM_ITEMS = 850;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        func = FUNC_LOAD;
	logic signed [31:0] grad_value = '0;
	logic [31:0] hess_value = '0;
	logic        last_in = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic signed [31:0] precond_value;
	logic [9:0]  element_index;
	logic [31:0] scale_factor;
	logic        copied_unchanged;
	logic        last_out;
	int          errors, pending;

	int snd_idle = 26; // percent of cycles in which the sender holds back
	int rcv_idle = 86; // percent of cycles in which the receiver stalls
	int phase = 0;
	int sent = 0;

	always #5 clk = ~clk;

	pseudo_hessian_precondition_normalize_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_stall(req_stall), .func(func),
		.grad_value(grad_value), .hess_value(hess_value), .last_in(last_in),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .precond_value(precond_value),
		.element_index(element_index), .scale_factor(scale_factor),
		.copied_unchanged(copied_unchanged), .last_out(last_out)
	);

	phpn_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_stall(req_stall), .func(func),
		.grad_value(grad_value), .hess_value(hess_value), .last_in(last_in),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .precond_value(precond_value),
		.element_index(element_index), .scale_factor(scale_factor),
		.copied_unchanged(copied_unchanged), .last_out(last_out),
		.errors(errors), .pending(pending)
	);

	// Receiver: random stall, plus one long hold-off in the last phase so the
	// output register fills and the block has to stall its request side.
	int hold_left = 0;
	bit hold_done = 0;
	int rsp_seen = 0;
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && phase == 2)
			rsp_seen++;
		if (!hold_done && phase == 2 && rsp_seen >= 40) begin
			hold_done = 1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// Watchdog: count cycles without any transfer on either channel.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one request; hold the payload until it is taken.
	task automatic xfer(input logic f, input logic [31:0] g, input logic [31:0] h,
			input logic l);
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		grad_value <= g;
		hess_value <= h;
		last_in <= l;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic fetch();
		xfer(FUNC_FETCH, $urandom, $urandom, $urandom_range(1));
	endtask

	// Drain: wait for all expected results, then for the request side to stay
	// free long enough that any pass still running has finished.
	task automatic drain();
		int calm;
		calm = 0;
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		while (calm < 80) begin
			@(posedge clk);
			calm = req_stall ? 0 : calm + 1;
		end
	endtask

	task automatic write_eps(input logic [23:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] pick_grad();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom_range(2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_hess(input int flavor);
		case (flavor)
			0: return 32'd0;
			1: return $urandom_range(255);
			2: return ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	task automatic load_vector(input int len, input int flavor);
		for (int i = 0; i < len; i++)
			xfer(FUNC_LOAD, pick_grad(), pick_hess(flavor), i == len - 1);
	endtask

	function automatic logic [23:0] pick_eps();
		case ($urandom_range(4))
			0: return 24'd0;
			1: return 24'hFF_FFFF;
			2: return EPS_RESET;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int len, flavor;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fetch with nothing ready, then extremes of every field.
		fetch();
		xfer(FUNC_LOAD, 32'h7FFF_FFFF, 32'd0, 1'b0);
		xfer(FUNC_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		xfer(FUNC_LOAD, 32'hFFFF_FFFF, 32'd1, 1'b0);
		xfer(FUNC_LOAD, 32'd0, 32'h0100_0000, 1'b1);
		repeat (5) fetch(); // one past the end gives nothing
		drain();
		// write the ratio register between passes
		write_eps(24'hFF_FFFF);
		xfer(FUNC_LOAD, 32'h0123_4567, 32'd0, 1'b0);
		xfer(FUNC_LOAD, 32'h8000_0000, 32'd0, 1'b1); // all-zero Hessian: pass-through
		repeat (2) fetch();
		xfer(FUNC_LOAD, 32'd0, 32'h0000_0010, 1'b0);
		xfer(FUNC_LOAD, 32'd0, 32'hFFFF_FFFF, 1'b1); // zero preconditioned sum
		repeat (2) fetch();
		drain();
		write_eps(24'd0); // threshold rounds to zero and is raised to one LSB
		xfer(FUNC_LOAD, 32'h7FFF_FFFF, 32'd0, 1'b0);
		xfer(FUNC_LOAD, 32'h8000_0000, 32'd3, 1'b1);
		repeat (2) fetch();
		drain();
		write_eps(EPS_RESET);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase == 0 && sent >= RANDOM_ITEMS / 3) begin
				drain();
				phase = 1;
				snd_idle = 86;
				rcv_idle = 26;
			end else if (phase == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
				drain();
				phase = 2;
				snd_idle = 0;
				rcv_idle = 0;
				write_eps(pick_eps());
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			flavor = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3);
			if ($urandom_range(9) == 0) begin
				// noise: fetch in the middle of a load, vector dropped half read
				xfer(FUNC_LOAD, pick_grad(), pick_hess(flavor), 1'b0);
				fetch();
			end
			load_vector(len, flavor);
			repeat (($urandom_range(4) == 0) ? $urandom_range(len) : len + $urandom_range(2))
				fetch();
			if ($urandom_range(5) == 0) begin
				drain();
				write_eps(pick_eps());
			end
		end
		// the long receiver hold-off needs a steady fetch stream in the last phase
		if (!hold_done) begin
			load_vector(60, 2);
			repeat (60) fetch();
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ pseudo_hessian_precondition_normalize_core.f @@
sv/phpn_pkg.sv
sv/phpn_ram.sv
sv/phpn_div.sv
sv/phpn_sqrt.sv
sv/pseudo_hessian_precondition_normalize_core.sv
verif/phpn_scoreboard.sv
verif/tb_pseudo_hessian_precondition_normalize_core.sv
